FILE: hdl/wpb_pkg.sv
package wpb_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned EdgeW  = 31;
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 128;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OFFGRID   = 2'd1,
    ST_ZERO_INC  = 2'd2,
    ST_BAD_WIDTH = 2'd3
  } status_t;

  typedef struct packed {
    logic              is_first;
    logic              is_last;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic              start_along_x;
    logic [CoordW-1:0] half_width;
    logic [CoordW-1:0] increment;
  } item_t;

  typedef struct packed {
    logic [EdgeW-1:0] left_x;
    logic [EdgeW-1:0] right_x;
    logic [EdgeW-1:0] bottom_y;
    logic [EdgeW-1:0] top_y;
    status_t          status;
    logic             end_of_wire;
  } box_t;

  // signed halving, truncating toward zero
  function automatic logic [EdgeW-1:0] halve(input logic [CoordW-1:0] v);
    logic [CoordW-1:0] s;
    s = v + {{(CoordW-1){1'b0}}, v[CoordW-1]};
    return s[CoordW-1:1];
  endfunction

endpackage

FILE: hdl/wpb_seg.sv
module wpb_seg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  wpb_pkg::item_t item,
  output logic          has_res,
  output wpb_pkg::box_t res
);

  logic [wpb_pkg::CoordW-1:0] pos_x_r, pos_y_r, hw_r;
  logic along_x_r, first_seg_r, dropping_r;

  logic [wpb_pkg::CoordW-1:0] pos_x_nxt, pos_y_nxt, hw_nxt;
  logic along_x_nxt, first_seg_nxt, dropping_nxt;

  // effective path state after a possible wire start
  logic [wpb_pkg::CoordW-1:0] px, py, w;
  logic ax, fs;
  logic bad_width, zero_inc, positive;
  logic [wpb_pkg::CoordW-1:0] start, stop, l, r, b, t;

  always_comb begin
    bad_width = item.is_first &&
                ((item.half_width == '0) || item.half_width[wpb_pkg::CoordW-1]);
    zero_inc  = (item.increment == '0);
    positive  = !item.increment[wpb_pkg::CoordW-1];

    px = item.is_first ? item.start_x : pos_x_r;
    py = item.is_first ? item.start_y : pos_y_r;
    ax = item.is_first ? item.start_along_x : along_x_r;
    w  = item.is_first ? item.half_width : hw_r;
    fs = item.is_first ? 1'b1 : first_seg_r;

    start = ax ? px : py;
    stop  = start + item.increment;
    if (!fs) begin
      start = positive ? start - w : start + w;
    end
    if (!item.is_last) begin
      stop = positive ? stop + w : stop - w;
    end
    if (ax) begin
      l = start;
      r = stop;
      b = py - w;
      t = py + w;
    end else begin
      l = px - w;
      r = px + w;
      b = start;
      t = stop;
    end

    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    along_x_nxt   = along_x_r;
    hw_nxt        = hw_r;
    first_seg_nxt = first_seg_r;
    dropping_nxt  = dropping_r;

    has_res         = 1'b1;
    res.left_x      = '0;
    res.right_x     = '0;
    res.bottom_y    = '0;
    res.top_y       = '0;
    res.status      = wpb_pkg::ST_OK;
    res.end_of_wire = 1'b1;

    if (bad_width) begin
      res.status    = wpb_pkg::ST_BAD_WIDTH;
      dropping_nxt  = 1'b1;
      first_seg_nxt = 1'b1;
    end else if (!item.is_first && dropping_r) begin
      has_res = 1'b0;
    end else if (zero_inc) begin
      res.status    = wpb_pkg::ST_ZERO_INC;
      pos_x_nxt     = px;
      pos_y_nxt     = py;
      along_x_nxt   = ax;
      hw_nxt        = w;
      first_seg_nxt = fs;
      dropping_nxt  = 1'b1;
    end else begin
      res.left_x      = wpb_pkg::halve(l);
      res.right_x     = wpb_pkg::halve(r);
      res.bottom_y    = wpb_pkg::halve(b);
      res.top_y       = wpb_pkg::halve(t);
      res.status      = ((l[0] | r[0] | b[0] | t[0]) != 1'b0) ?
                        wpb_pkg::ST_OFFGRID : wpb_pkg::ST_OK;
      res.end_of_wire = item.is_last;
      pos_x_nxt       = ax ? px + item.increment : px;
      pos_y_nxt       = ax ? py : py + item.increment;
      along_x_nxt     = !ax;
      hw_nxt          = w;
      first_seg_nxt   = item.is_last;
      dropping_nxt    = item.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      along_x_r   <= 1'b0;
      hw_r        <= '0;
      first_seg_r <= 1'b1;
      dropping_r  <= 1'b0;
    end else if (adv) begin
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      along_x_r   <= along_x_nxt;
      hw_r        <= hw_nxt;
      first_seg_r <= first_seg_nxt;
      dropping_r  <= dropping_nxt;
    end
  end

endmodule

FILE: hdl/wire_path_to_boxes_core.sv
// Wire path to boxes: each request is one segment of a layout wire, and the
// block answers with at most one box (or an error result) per request. It
// takes one request every clock cycle as long as results are taken when they
// are offered. A taken request sits in the input register while the segment
// logic works on it; its box is loaded into the result register, which offers
// it, when the input stage advances. A held result blocks the input only when
// the next request also makes a result.
// The running path point is kept in the segment stage, so back to back
// segments of one wire need no bubbles.
// A wire whose width or increment is bad ends with an error result and its
// remaining requests are swallowed until the next request flagged as first.
module wire_path_to_boxes_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // start_x[31:0], start_y[63:32], start_along_x[64], half_width[96:65],
  // increment[128:97], zero fill above
  input  logic [wpb_pkg::InDataW-1:0]   in_tdata,
  // is_first[0]
  input  logic                          in_tuser,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // left_x[30:0], right_x[61:31], bottom_y[92:62], top_y[123:93], zero fill
  output logic [wpb_pkg::OutDataW-1:0]  out_tdata,
  // status[1:0]
  output logic [1:0]                    out_tuser,
  output logic                          out_tlast
);

  wpb_pkg::item_t s1_item_r, s1_item_nxt;
  logic           s1_v_r, s1_v_nxt;
  wpb_pkg::box_t  out_res_r, out_res_nxt;
  logic           out_v_r, out_v_nxt;

  wpb_pkg::box_t  seg_res;
  logic           seg_has_res;
  logic           out_free, s1_adv, in_fire;

  assign out_free  = !out_v_r || out_tready;
  assign s1_adv    = s1_v_r && (!seg_has_res || out_free);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_item_nxt.is_first      = in_tuser;
    s1_item_nxt.is_last       = in_tlast;
    s1_item_nxt.start_x       = in_tdata[31:0];
    s1_item_nxt.start_y       = in_tdata[63:32];
    s1_item_nxt.start_along_x = in_tdata[64];
    s1_item_nxt.half_width    = in_tdata[96:65];
    s1_item_nxt.increment     = in_tdata[128:97];

    s1_v_nxt = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);

    out_res_nxt = out_res_r;
    out_v_nxt   = out_v_r;
    if (s1_adv && seg_has_res) begin
      out_res_nxt = seg_res;
      out_v_nxt   = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  wpb_seg u_seg (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (s1_adv),
    .item    (s1_item_r),
    .has_res (seg_has_res),
    .res     (seg_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= s1_item_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(wpb_pkg::OutDataW - 4*wpb_pkg::EdgeW){1'b0}},
                       out_res_r.top_y, out_res_r.bottom_y,
                       out_res_r.right_x, out_res_r.left_x};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.end_of_wire;

  // error results always close the wire
  a_err_ends_wire: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == wpb_pkg::ST_ZERO_INC ||
                   out_tuser == wpb_pkg::ST_BAD_WIDTH) |-> out_tlast)
    else $error("error result without end of wire");

  // error results carry no box
  a_err_no_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == wpb_pkg::ST_ZERO_INC ||
                   out_tuser == wpb_pkg::ST_BAD_WIDTH) |-> out_tdata == '0)
    else $error("error result with nonzero box");

  // a held segment stays in the input stage
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r && $stable(s1_item_r))
    else $error("input stage lost a held request");

  // a result is only loaded into a free output register
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r && $stable(out_res_r))
    else $error("pending result overwritten");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

FILE: test/tb_wire_path_to_boxes_core.sv
module tb_wire_path_to_boxes_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod = 4;
  localparam int RandomBoxes = 1350;
  localparam int StallLimit = 2000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [wpb_pkg::InDataW-1:0] in_tdata;
  logic in_tuser;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [wpb_pkg::OutDataW-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  always #(ClkPeriod / 2) clk = ~clk;

  wire_path_to_boxes_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // running path point as the block should hold it
  logic [31:0] trace_x = '0;
  logic [31:0] trace_y = '0;
  logic        trace_along_x = 1'b0;
  logic [31:0] trace_hw = '0;
  logic        trace_fresh = 1'b1;
  logic        trace_skip = 1'b0;

  wpb_pkg::box_t pending_boxes[$];
  int   mismatches = 0;
  int   boxes_sent = 0;
  int   idle_cycles = 0;
  int   cycle_count = 0;
  bit   quiet_in = 1'b0;
  bit   quiet_out = 1'b0;
  wpb_pkg::box_t got_box;
  wpb_pkg::box_t oldest_box;

  wpb_pkg::item_t plan_req[$];
  bit    plan_typed[$];
  wpb_pkg::box_t  plan_want[$];

  function automatic logic [wpb_pkg::EdgeW-1:0] half_edge(input logic [31:0] v);
    logic signed [31:0] q;
    q = $signed(v) / 2;
    return q[wpb_pkg::EdgeW-1:0];
  endfunction

  // advances the path by one request, returns 1 when a box comes out
  function automatic bit segment_box(input wpb_pkg::item_t r, output wpb_pkg::box_t b);
    logic [31:0] w, a, z, lf, rt, bt, tp;
    bit up;
    b = '0;
    if (r.is_first) begin
      trace_skip = 1'b0;
      trace_fresh = 1'b1;
      if (r.half_width == '0 || r.half_width[31]) begin
        trace_skip = 1'b1;
        b.status = wpb_pkg::ST_BAD_WIDTH;
        b.end_of_wire = 1'b1;
        return 1'b1;
      end
      trace_x = r.start_x;
      trace_y = r.start_y;
      trace_along_x = r.start_along_x;
      trace_hw = r.half_width;
    end else if (trace_skip) begin
      return 1'b0;
    end
    if (r.increment == '0) begin
      trace_skip = 1'b1;
      b.status = wpb_pkg::ST_ZERO_INC;
      b.end_of_wire = 1'b1;
      return 1'b1;
    end
    w = trace_hw;
    up = !r.increment[31];
    a = trace_along_x ? trace_x : trace_y;
    z = a + r.increment;
    // inner joints overlap by half width, the wire's own ends do not
    if (!trace_fresh) a = up ? a - w : a + w;
    if (!r.is_last) z = up ? z + w : z - w;
    if (trace_along_x) begin
      lf = a;
      rt = z;
      bt = trace_y - w;
      tp = trace_y + w;
      trace_x = trace_x + r.increment;
    end else begin
      lf = trace_x - w;
      rt = trace_x + w;
      bt = a;
      tp = z;
      trace_y = trace_y + r.increment;
    end
    trace_along_x = !trace_along_x;
    trace_fresh = 1'b0;
    b.left_x = half_edge(lf);
    b.right_x = half_edge(rt);
    b.bottom_y = half_edge(bt);
    b.top_y = half_edge(tp);
    b.status = (lf[0] | rt[0] | bt[0] | tp[0]) ? wpb_pkg::ST_OFFGRID : wpb_pkg::ST_OK;
    b.end_of_wire = r.is_last;
    if (r.is_last) begin
      trace_skip = 1'b1;
      trace_fresh = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic wpb_pkg::item_t mk(input bit f, input bit l, input logic [31:0] x,
                                        input logic [31:0] y, input bit ax,
                                        input logic [31:0] hw, input logic [31:0] inc);
    wpb_pkg::item_t r;
    r.is_first = f;
    r.is_last = l;
    r.start_x = x;
    r.start_y = y;
    r.start_along_x = ax;
    r.half_width = hw;
    r.increment = inc;
    return r;
  endfunction

  function automatic wpb_pkg::box_t want_box(input logic [wpb_pkg::EdgeW-1:0] l,
                                             input logic [wpb_pkg::EdgeW-1:0] r,
                                             input logic [wpb_pkg::EdgeW-1:0] b,
                                             input logic [wpb_pkg::EdgeW-1:0] t,
                                             input wpb_pkg::status_t s, input bit eow);
    wpb_pkg::box_t v;
    v.left_x = l;
    v.right_x = r;
    v.bottom_y = b;
    v.top_y = t;
    v.status = s;
    v.end_of_wire = eow;
    return v;
  endfunction

  task automatic add_row(input wpb_pkg::item_t r, input bit typed, input wpb_pkg::box_t w);
    plan_req.push_back(r);
    plan_typed.push_back(typed);
    plan_want.push_back(w);
  endtask

  function automatic logic [31:0] rand_step();
    logic [31:0] s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      s = $urandom_range(1, 200);
      if ($urandom_range(0, 1)) s = -s;
    end else if (pick < 97) begin
      s = $urandom;
    end else begin
      s = '0;
    end
    return s;
  endfunction

  function automatic int pick_gap(input bit calm);
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 65) return 0;
    if (pick < 90) return $urandom_range(1, 2);
    if (pick < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, exp_val);
  endtask

  task automatic send_request(input wpb_pkg::item_t r, input bit typed,
                              input wpb_pkg::box_t w, output bit made);
    wpb_pkg::box_t b;
    int n;
    n = pick_gap(quiet_in);
    repeat (n) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {7'b0, r.increment, r.half_width, r.start_along_x, r.start_y, r.start_x};
    in_tuser = r.is_first;
    in_tlast = r.is_last;
    do @(posedge clk); while (!in_tready);
    made = segment_box(r, b);
    if (typed) pending_boxes.push_back(w);
    else if (made) pending_boxes.push_back(b);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
  endtask

  task automatic send_wire();
    wpb_pkg::item_t r;
    logic [31:0] hw, x0, y0;
    int nseg, pick;
    bit cut, made;
    pick = $urandom_range(0, 99);
    if (pick < 70) hw = $urandom_range(1, 64);
    else if (pick < 93) hw = $urandom & 32'h7FFF_FFFF;
    else if (pick < 96) hw = '0;
    else hw = $urandom | 32'h8000_0000;
    if ($urandom_range(0, 1)) begin
      x0 = $urandom_range(0, 2000) - 1000;
      y0 = $urandom_range(0, 2000) - 1000;
    end else begin
      x0 = $urandom;
      y0 = $urandom;
    end
    nseg = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    // now and then a wire never gets its closing request
    cut = ($urandom_range(0, 19) == 0);
    for (int i = 0; i < nseg; i++) begin
      if (i == 0) r = mk(1'b1, 1'b0, x0, y0, 1'($urandom_range(0, 1)), hw, rand_step());
      else r = mk(1'b0, 1'b0, $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom,
                  rand_step());
      r.is_last = (i == nseg - 1) && !cut;
      send_request(r, 1'b0, '0, made);
      boxes_sent += int'(made);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0) begin
      quiet_in <= ($urandom_range(0, 3) == 0);
      quiet_out <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int hold;
    out_tready = 1'b0;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        out_tready = 1'b1;
        if (!quiet_out && $urandom_range(0, 3) == 0) hold = pick_gap(1'b0) + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_box.left_x = out_tdata[30:0];
      got_box.right_x = out_tdata[61:31];
      got_box.bottom_y = out_tdata[92:62];
      got_box.top_y = out_tdata[123:93];
      got_box.status = wpb_pkg::status_t'(out_tuser);
      got_box.end_of_wire = out_tlast;
      if (pending_boxes.size() == 0) begin
        report_mismatch("unexpected result", 32'(got_box.status), '0);
      end else begin
        oldest_box = pending_boxes.pop_front();
        if (got_box.left_x !== oldest_box.left_x)
          report_mismatch("left_x", 32'(got_box.left_x), 32'(oldest_box.left_x));
        if (got_box.right_x !== oldest_box.right_x)
          report_mismatch("right_x", 32'(got_box.right_x), 32'(oldest_box.right_x));
        if (got_box.bottom_y !== oldest_box.bottom_y)
          report_mismatch("bottom_y", 32'(got_box.bottom_y), 32'(oldest_box.bottom_y));
        if (got_box.top_y !== oldest_box.top_y)
          report_mismatch("top_y", 32'(got_box.top_y), 32'(oldest_box.top_y));
        if (got_box.status !== oldest_box.status)
          report_mismatch("status", 32'(got_box.status), 32'(oldest_box.status));
        if (got_box.end_of_wire !== oldest_box.end_of_wire)
          report_mismatch("end_of_wire", 32'(got_box.end_of_wire),
                          32'(oldest_box.end_of_wire));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    bit made;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;

    // no wire yet: the reset point along y with zero width
    add_row(mk(1'b0, 1'b0, '1, '1, 1'b1, '1, 32'd4), 1'b1,
            want_box('0, '0, '0, 31'd2, wpb_pkg::ST_OK, 1'b0));
    add_row(mk(1'b0, 1'b1, 0, 0, 1'b0, 0, -32'sd6), 1'b0, '0);
    add_row(mk(1'b0, 1'b0, 0, 0, 1'b0, 0, 32'd8), 1'b0, '0);
    add_row(mk(1'b1, 1'b0, 5, 5, 1'b1, 0, 32'd10), 1'b1,
            want_box('0, '0, '0, '0, wpb_pkg::ST_BAD_WIDTH, 1'b1));
    add_row(mk(1'b0, 1'b1, 0, 0, 1'b0, 0, 32'd5), 1'b0, '0);
    add_row(mk(1'b1, 1'b1, 5, 5, 1'b0, 32'h8000_0000, 32'd3), 1'b1,
            want_box('0, '0, '0, '0, wpb_pkg::ST_BAD_WIDTH, 1'b1));
    add_row(mk(1'b1, 1'b0, 10, 20, 1'b1, 3, 32'd100), 1'b0, '0);
    add_row(mk(1'b0, 1'b0, '1, '1, 1'b0, '1, 0), 1'b1,
            want_box('0, '0, '0, '0, wpb_pkg::ST_ZERO_INC, 1'b1));
    add_row(mk(1'b0, 1'b1, 0, 0, 1'b0, 0, 32'd7), 1'b0, '0);
    add_row(mk(1'b1, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 2, 32'h7FFF_FFFF), 1'b0, '0);
    add_row(mk(1'b0, 1'b0, '1, '1, 1'b1, '1, 32'h8000_0000), 1'b0, '0);
    add_row(mk(1'b0, 1'b1, 0, 0, 1'b0, 0, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(mk(1'b1, 1'b1, '1, '1, 1'b1, 32'h7FFF_FFFF, 32'd1), 1'b0, '0);
    add_row(mk(1'b1, 1'b0, 0, 0, 1'b1, 1, 0), 1'b1,
            want_box('0, '0, '0, '0, wpb_pkg::ST_ZERO_INC, 1'b1));
    add_row(mk(1'b1, 1'b0, 2, 2, 1'b1, 4, 32'd8), 1'b0, '0);
    add_row(mk(1'b0, 1'b0, '1, 0, 1'b1, 7, 32'd8), 1'b0, '0);
    add_row(mk(1'b0, 1'b0, 0, '1, 1'b0, 0, -32'sd8), 1'b0, '0);
    add_row(mk(1'b0, 1'b1, 0, 0, 1'b1, 0, 32'd8), 1'b0, '0);
    add_row(mk(1'b1, 1'b1, 7, 3, 1'b0, 1, 32'd3), 1'b0, '0);
    add_row(mk(1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF,
               32'h8000_0000), 1'b0, '0);
    add_row(mk(1'b0, 1'b1, 0, 0, 1'b0, 0, 32'h7FFF_FFFF), 1'b0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan_req[i]) send_request(plan_req[i], plan_typed[i], plan_want[i], made);
    drain_results();

    for (int n = 0; boxes_sent < RandomBoxes; n++) begin
      if ($urandom_range(0, 19) == 0)
        send_request(mk(1'b0, 1'($urandom_range(0, 1)), $urandom, $urandom,
                        1'($urandom_range(0, 1)), $urandom, rand_step()), 1'b0, '0, made);
      send_wire();
      if (n % 60 == 59) drain_results();
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
